// File: rtl/core/tml_pkg.sv
package tml_pkg;

  localparam int KNOT_COUNT    = 9;
  localparam int KNOT_IDX_W    = 4;
  localparam int SAMPLE_PORT_W = 12;
  localparam int CHANNEL_W     = 3;
  localparam int CHANNEL_MAX   = 3;
  localparam int NUM_W         = 12;
  localparam int TEMP_W        = 11;
  localparam int TEMP_MIN      = -1024;
  localparam int TEMP_MAX      = 1023;

  // calibration knots: ADC code, temperature (0.1 degC), slope as N/D
  localparam int KNOT_ADU  [KNOT_COUNT] = '{427, 468, 514, 623, 754, 910, 1087, 1295, 1538};
  localparam int KNOT_TEMP [KNOT_COUNT] = '{-200, -180, -159, -116, -72, -26, 23, 75, 132};
  localparam int SLOPE_NUM [KNOT_COUNT] = '{1377, 295, 258, 110, 291, 77, 1657, 191, 120};
  localparam int SLOPE_DEN [KNOT_COUNT] = '{2728, 654, 659, 327, 977, 285, 6629, 812, 533};

  // stage enables shared by all lanes
  typedef struct packed {
    logic prod_en;
    logic quot_en;
  } lane_ctl_t;

endpackage

// File: rtl/core/tml_median.sv
module tml_median #(
  parameter int SB = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [SB-1:0] samples [9],
  input  logic          chan_bad,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [SB-1:0] median,
  output logic          chan_bad_out
);

  typedef logic [SB-1:0] smp_t;
  typedef smp_t vec_t [9];

  // compare-exchange: smaller value ends at lo
  function automatic vec_t ce(input vec_t a, input logic [3:0] lo, input logic [3:0] hi);
    vec_t r;
    r = a;
    if (a[lo] > a[hi]) begin
      r[lo] = a[hi];
      r[hi] = a[lo];
    end
    return r;
  endfunction

  vec_t s1, s2, s1_next, s2_next;
  smp_t median_next;
  logic v1, v2, v3;
  logic bad1, bad2, bad3;
  logic r1, r2, r3;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    vec_t x;
    x = samples;
    x = ce(x, 4'd1, 4'd2); x = ce(x, 4'd4, 4'd5); x = ce(x, 4'd7, 4'd8);
    x = ce(x, 4'd0, 4'd1); x = ce(x, 4'd3, 4'd4); x = ce(x, 4'd6, 4'd7);
    x = ce(x, 4'd1, 4'd2); x = ce(x, 4'd4, 4'd5); x = ce(x, 4'd7, 4'd8);
    s1_next = x;
  end

  always_comb begin
    vec_t x;
    x = s1;
    x = ce(x, 4'd0, 4'd3); x = ce(x, 4'd5, 4'd8); x = ce(x, 4'd4, 4'd7);
    x = ce(x, 4'd3, 4'd6); x = ce(x, 4'd1, 4'd4); x = ce(x, 4'd2, 4'd5);
    x = ce(x, 4'd4, 4'd7);
    s2_next = x;
  end

  always_comb begin
    vec_t x;
    x = s2;
    x = ce(x, 4'd4, 4'd2);
    x = ce(x, 4'd6, 4'd4);
    x = ce(x, 4'd4, 4'd2);
    median_next = x[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1   <= s1_next;
      bad1 <= chan_bad;
    end
    if (r2) begin
      s2   <= s2_next;
      bad2 <= bad1;
    end
    if (r3) begin
      median <= median_next;
      bad3   <= bad2;
    end
  end

  assign out_valid    = v3;
  assign chan_bad_out = bad3;

endmodule

// File: rtl/core/tml_lane.sv
module tml_lane #(
  parameter int SB   = 12,
  parameter int KNOT = 0
) (
  input  logic                  clk,
  input  tml_pkg::lane_ctl_t    ctl,
  input  logic [SB-1:0]         median,
  output logic signed [SB+2:0]  temp
);

  import tml_pkg::*;

  localparam int DIFF_W  = SB + 1;
  localparam int PROD_W  = SB + 12;
  localparam int MAG_W   = PROD_W - 1;
  localparam int SHIFT   = SB + 24;
  localparam int RECIP_W = SB + 16;
  localparam int WIDE_W  = MAG_W + RECIP_W;
  localparam int QW      = SB + 1;
  localparam int TW      = SB + 3;

  localparam logic signed [DIFF_W-1:0] ADU_C = DIFF_W'(KNOT_ADU[KNOT]);
  localparam logic signed [NUM_W-1:0]  NUM_C = NUM_W'(SLOPE_NUM[KNOT]);
  localparam logic signed [TW-1:0]     T_C   = TW'(KNOT_TEMP[KNOT]);
  // ceil(2^SHIFT / D): exact floor division for every magnitude below 2^MAG_W
  localparam longint DEN        = longint'(SLOPE_DEN[KNOT]);
  localparam longint RECIP_FULL = ((longint'(1) <<< SHIFT) + DEN - 1) / DEN;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod, prod_next, mag_full;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [WIDE_W-1:0]        wide;
  logic [QW-1:0]            qmag;
  logic signed [TW-1:0]     q_s, temp_next;

  assign diff      = $signed({1'b0, median}) - ADU_C;
  assign prod_next = PROD_W'(diff) * PROD_W'(NUM_C);

  always_ff @(posedge clk) begin
    if (ctl.prod_en) prod <= prod_next;
  end

  // truncating division: divide the magnitude, then restore the sign
  assign neg       = prod[PROD_W-1];
  assign mag_full  = neg ? -prod : prod;
  assign mag       = mag_full[MAG_W-1:0];
  assign wide      = WIDE_W'(mag) * WIDE_W'(RECIP);
  assign qmag      = wide[SHIFT +: QW];
  assign q_s       = $signed(TW'({1'b0, qmag}));
  assign temp_next = T_C + (neg ? -q_s : q_s);

  always_ff @(posedge clk) begin
    if (ctl.quot_en) temp <= temp_next;
  end

endmodule

// File: rtl/core/tml_merge.sv
module tml_merge #(
  parameter int SB = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SB+2:0]                lane_temp [tml_pkg::KNOT_COUNT],
  input  logic [SB-1:0]                       median,
  input  logic                                chan_bad,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tml_pkg::TEMP_W-1:0]   temperature_tenths,
  output logic                                channel_invalid
);

  import tml_pkg::*;

  localparam int TW = SB + 3;
  localparam logic signed [TW-1:0] SAT_LO = TW'(TEMP_MIN);
  localparam logic signed [TW-1:0] SAT_HI = TW'(TEMP_MAX);

  logic [KNOT_IDX_W-1:0]     idx;
  logic signed [TW-1:0]      sel;
  logic signed [TEMP_W-1:0]  temp_next;

  assign in_ready = !out_valid || out_ready;

  // interval: last knot not above the median, first interval below all knots
  always_comb begin
    idx = '0;
    for (int k = 0; k < KNOT_COUNT; k++) begin
      if (median >= SB'(KNOT_ADU[k])) idx = KNOT_IDX_W'(k);
    end
  end

  assign sel = lane_temp[idx];

  always_comb begin
    if (chan_bad) begin
      temp_next = '0;
    end else if (sel < SAT_LO) begin
      temp_next = TEMP_W'(SAT_LO);
    end else if (sel > SAT_HI) begin
      temp_next = TEMP_W'(SAT_HI);
    end else begin
      temp_next = TEMP_W'(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      temperature_tenths <= temp_next;
      channel_invalid    <= chan_bad;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_invalid |-> temperature_tenths == '0)
    else $error("invalid channel beat carries non-zero temperature");

endmodule

// File: rtl/core/thermistor_median_linearizer_unit.sv
// Thermistor median linearizer.
// Input channel (in_valid/in_ready): one beat carries nine ADC samples of one
// thermistor and its channel number. Only the low SAMPLE_BITS of each sample
// are used.
// Output channel (out_valid/out_ready): one beat per input beat, in order:
// temperature in 0.1 degC, saturated to -1024..1023, and channel_invalid,
// set (with temperature 0) for channels 4 to 7.
// Pipeline: 3 median-network stages, 2 lane stages and 1 output register
// lie between input acceptance and out_valid.
// Throughput: one beat per cycle while the receiver takes beats; every stage
// has its own valid bit, so bubbles close up behind a stalled receiver.
// Reset (rst, synchronous): empties every stage; nothing is in flight after.
// Receiver stall: the output register holds its beat; upstream stages keep
// filling until full, then in_ready drops.
// Structure: median network, nine segment lanes (one per knot, each doing a
// constant multiply and a reciprocal divide), merge stage picking the
// interval and saturating.
module thermistor_median_linearizer_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_a,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_b,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_c,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_d,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_e,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_f,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_g,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_h,
  input  logic [tml_pkg::SAMPLE_PORT_W-1:0]     sample_i,
  input  logic [tml_pkg::CHANNEL_W-1:0]         channel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tml_pkg::TEMP_W-1:0]     temperature_tenths,
  output logic                                  channel_invalid
);

  import tml_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic [SB-1:0]         samples [9];
  logic                  chan_bad;

  // median stage outputs
  logic                  m_valid, m_ready, m_bad;
  logic [SB-1:0]         m_median;

  // lane stage side band
  logic                  l1_valid, l2_valid, l1_ready, l2_ready;
  logic [SB-1:0]         med_l1, med_l2;
  logic                  bad_l1, bad_l2;
  lane_ctl_t             ctl;
  logic signed [SB+2:0]  lane_temp [KNOT_COUNT];
  logic                  mg_ready;

  assign samples[0] = sample_a[SB-1:0];
  assign samples[1] = sample_b[SB-1:0];
  assign samples[2] = sample_c[SB-1:0];
  assign samples[3] = sample_d[SB-1:0];
  assign samples[4] = sample_e[SB-1:0];
  assign samples[5] = sample_f[SB-1:0];
  assign samples[6] = sample_g[SB-1:0];
  assign samples[7] = sample_h[SB-1:0];
  assign samples[8] = sample_i[SB-1:0];
  assign chan_bad   = channel > CHANNEL_W'(CHANNEL_MAX);

  tml_median #(.SB(SB)) u_median (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .samples      (samples),
    .chan_bad     (chan_bad),
    .out_valid    (m_valid),
    .out_ready    (m_ready),
    .median       (m_median),
    .chan_bad_out (m_bad)
  );

  // lane pipeline control: a stage moves when empty or when the next moves
  assign l2_ready    = !l2_valid || mg_ready;
  assign l1_ready    = !l1_valid || l2_ready;
  assign m_ready     = l1_ready;
  assign ctl.prod_en = l1_ready;
  assign ctl.quot_en = l2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
      l2_valid <= 1'b0;
    end else begin
      if (l1_ready) l1_valid <= m_valid;
      if (l2_ready) l2_valid <= l1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (l1_ready) begin
      med_l1 <= m_median;
      bad_l1 <= m_bad;
    end
    if (l2_ready) begin
      med_l2 <= med_l1;
      bad_l2 <= bad_l1;
    end
  end

  // one lane per knot; each evaluates its own segment for every beat
  for (genvar g = 0; g < KNOT_COUNT; g++) begin : g_lane
    tml_lane #(.SB(SB), .KNOT(g)) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .median (m_median),
      .temp   (lane_temp[g])
    );
  end

  tml_merge #(.SB(SB)) u_merge (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (l2_valid),
    .in_ready           (mg_ready),
    .lane_temp          (lane_temp),
    .median             (med_l2),
    .chan_bad           (bad_l2),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .temperature_tenths (temperature_tenths),
    .channel_invalid    (channel_invalid)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present straight after reset");

  a_l2_hold: assert property (@(posedge clk) disable iff (rst)
    l2_valid && !mg_ready |=> l2_valid)
    else $error("lane stage 2 dropped a beat while merge stalled");

  a_l1_hold: assert property (@(posedge clk) disable iff (rst)
    l1_valid && !l2_ready |=> l1_valid && $stable(med_l1))
    else $error("lane stage 1 changed while stalled");

endmodule
